// File: rtl/hgd_pkg.sv
// Package of shared types, codes and constants for the head gesture detector.
package hgd_pkg;

   // Mode codes of the gesture machine; a classified sample uses the same codes.
   typedef enum logic [2:0] {
      MODE_HOLD  = 3'd0,
      MODE_IDLE  = 3'd1,
      MODE_LEFT  = 3'd2,
      MODE_RIGHT = 3'd3,
      MODE_DOWN  = 3'd4,
      MODE_UP    = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      GEST_NONE  = 3'd0,
      GEST_LEFT  = 3'd1,
      GEST_RIGHT = 3'd2,
      GEST_DOWN  = 3'd3,
      GEST_UP    = 3'd4
   } gesture_type;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_LEFT_LIMIT   = 3'd0;
   localparam logic [2:0] CSR_RIGHT_LIMIT  = 3'd1;
   localparam logic [2:0] CSR_DOWN_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_UP_LIMIT     = 3'd3;
   localparam logic [2:0] CSR_HOLD_TIMEOUT = 3'd4;
   localparam logic [2:0] CSR_MIN_TIME     = 3'd5;

   // Reset values: 0.6, -0.4, -0.4 and 0.1 in Q1.14, then microseconds.
   localparam logic signed [15:0] LEFT_LIMIT_RESET   = 16'sd9830;
   localparam logic signed [15:0] RIGHT_LIMIT_RESET  = -16'sd6554;
   localparam logic signed [15:0] DOWN_LIMIT_RESET   = -16'sd6554;
   localparam logic signed [15:0] UP_LIMIT_RESET     = 16'sd1638;
   localparam logic [31:0]        HOLD_TIMEOUT_RESET = 32'd1500000;
   localparam logic [31:0]        MIN_TIME_RESET     = 32'd200000;

   // Depth of the queue between the front and back parts.
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
      logic [62:0]        sample_time;
   } req_type;

   typedef struct packed {
      gesture_type gesture;
      mode_type    mode_now;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] left_limit;
      logic signed [15:0] right_limit;
      logic signed [15:0] down_limit;
      logic signed [15:0] up_limit;
      logic [31:0]        hold_timeout;
      logic [31:0]        min_gesture_time;
   } cfg_type;

   // A classified sample as it travels through the queue.
   typedef struct packed {
      mode_type    cls;
      logic [62:0] sample_time;
   } item_type;

endpackage

// File: rtl/hgd_front.sv
// Front part: accepts samples, classifies them and registers the result.
module hgd_front import hgd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     item_valid,
   output item_type item,
   input  logic     item_stall
);

   logic     stage_valid_ff, stage_valid_in;
   item_type stage_ff;
   mode_type cls;
   logic     accept;

   // Priority: left, right, down, up, otherwise neutral.
   always_comb begin
      if (req_data.yaw > cfg.left_limit) begin
         cls = MODE_LEFT;
      end else if (req_data.yaw < cfg.right_limit) begin
         cls = MODE_RIGHT;
      end else if (req_data.pitch < cfg.down_limit) begin
         cls = MODE_DOWN;
      end else if (req_data.pitch > cfg.up_limit) begin
         cls = MODE_UP;
      end else begin
         cls = MODE_IDLE;
      end
   end

   assign req_stall      = stage_valid_ff && item_stall;
   assign accept         = req_valid && !req_stall;
   assign stage_valid_in = accept || (stage_valid_ff && item_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff.cls         <= cls;
         stage_ff.sample_time <= req_data.sample_time;
      end
   end

   assign item_valid = stage_valid_ff;
   assign item       = stage_ff;

endmodule

// File: rtl/hgd_queue.sv
// Short queue of classified samples between the front and back parts.
module hgd_queue import hgd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_stall,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_stall,
   output item_type pop_item
);

   item_type               entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   push, pop, full;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop        = pop_valid && !pop_stall;
   assign push_stall = full && !pop;
   assign push       = push_valid && !push_stall;
   assign pop_item   = entry_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntW'(QueueDepth))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

// File: rtl/hgd_back.sv
// Back part: the gesture mode machine and the registered result.
module hgd_back import hgd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_stall,
   input  item_type in_item,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   mode_type          mode_ff, mode_in;
   logic [62:0]       start_ff, start_in;
   logic              armed_ff, armed_in;
   gesture_type       fired;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;
   logic              take;
   logic signed [63:0] gap;
   logic              over_hold, over_min, neutral;

   assign in_stall     = rsp_valid_ff && rsp_stall;
   assign take         = in_valid && !in_stall;
   assign rsp_valid_in = take || (rsp_valid_ff && rsp_stall);

   // Both stamps are below 2^63, so the signed difference cannot overflow.
   assign gap       = $signed({1'b0, in_item.sample_time}) - $signed({1'b0, start_ff});
   assign over_hold = gap > $signed({32'b0, cfg.hold_timeout});
   assign over_min  = gap > $signed({32'b0, cfg.min_gesture_time});
   assign neutral   = (in_item.cls == MODE_IDLE);

   // Next mode.
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_IDLE: begin
            if (!neutral) begin
               mode_in = in_item.cls;
            end
         end
         MODE_LEFT, MODE_RIGHT, MODE_DOWN, MODE_UP: begin
            if (over_hold) begin
               mode_in = MODE_HOLD;
            end else if (neutral) begin
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = neutral ? MODE_IDLE : MODE_HOLD;
         end
      endcase
   end

   // Firing, arming and start time.
   always_comb begin
      fired    = GEST_NONE;
      armed_in = armed_ff;
      start_in = start_ff;
      case (mode_ff)
         MODE_IDLE: begin
            if (!neutral) begin
               armed_in = 1'b1;
               start_in = in_item.sample_time;
            end
         end
         MODE_LEFT, MODE_RIGHT, MODE_DOWN, MODE_UP: begin
            if (over_hold) begin
               armed_in = 1'b0;
            end else if (neutral && over_min && armed_ff) begin
               armed_in = 1'b0;
               case (mode_ff)
                  MODE_LEFT:  fired = GEST_LEFT;
                  MODE_RIGHT: fired = GEST_RIGHT;
                  MODE_DOWN:  fired = GEST_DOWN;
                  default:    fired = GEST_UP;
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_HOLD;
         start_ff     <= '0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            mode_ff  <= mode_in;
            start_ff <= start_in;
            armed_ff <= armed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff.gesture  <= fired;
         rsp_ff.mode_now <= mode_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fire_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.gesture != GEST_NONE) |-> (rsp_ff.mode_now == MODE_IDLE))
      else $error("gesture fired without returning to idle");

   a_hold_unarmed: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HOLD) |-> !armed_ff)
      else $error("armed while in hold");

   a_mode_matches: assert property (@(posedge clock) disable iff (reset)
      take |=> (rsp_ff.mode_now == mode_ff))
      else $error("reported mode differs from machine state");

endmodule

// File: rtl/head_gesture_detector.sv
// Top level of the head gesture detector: configuration registers and the two parts.
//
// Usage. Each transaction on the req_ channel carries one head rotation sample
// (pitch and yaw in signed Q1.14, timestamp in microseconds). It is taken at a
// rising edge with req_valid high and req_stall low. Every sample yields exactly
// one transaction on the rsp_ channel: the gesture fired by that sample (or none)
// and the mode after it, offered on rsp_valid until an edge with rsp_stall low.
// The front part classifies a sample against the four limits and registers it,
// a four-entry queue carries it to the back part, and the back part runs the
// mode machine and registers the result. A result is offered from the output
// register once its sample has passed the front register and the queue. While
// rsp_stall is low, one sample per cycle is sustained, set by the mode machine,
// which updates its state once per taken sample with one 64-bit subtraction.
// When the receiver stalls, the output register holds its result, the queue and
// then the front register fill, and only then does req_stall rise. Reset,
// synchronous and active high, restores the default limits and times, sets the
// mode to hold and clears the arming flag and the gesture start time. The csr_
// port is always ready; it should be written only while no samples are in flight.
module head_gesture_detector import hgd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type  cfg_ff;
   logic     front_valid, front_stall;
   item_type front_item;
   logic     queue_valid, queue_stall;
   item_type queue_item;

   // The register file never holds off a write.
   assign csr_ready = 1'b1;

   // Limits take the low half of the data; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_limit       <= LEFT_LIMIT_RESET;
         cfg_ff.right_limit      <= RIGHT_LIMIT_RESET;
         cfg_ff.down_limit       <= DOWN_LIMIT_RESET;
         cfg_ff.up_limit         <= UP_LIMIT_RESET;
         cfg_ff.hold_timeout     <= HOLD_TIMEOUT_RESET;
         cfg_ff.min_gesture_time <= MIN_TIME_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LEFT_LIMIT:   cfg_ff.left_limit       <= $signed(csr_data[15:0]);
            CSR_RIGHT_LIMIT:  cfg_ff.right_limit      <= $signed(csr_data[15:0]);
            CSR_DOWN_LIMIT:   cfg_ff.down_limit       <= $signed(csr_data[15:0]);
            CSR_UP_LIMIT:     cfg_ff.up_limit         <= $signed(csr_data[15:0]);
            CSR_HOLD_TIMEOUT: cfg_ff.hold_timeout     <= csr_data;
            CSR_MIN_TIME:     cfg_ff.min_gesture_time <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Classification stage.
   hgd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (front_valid),
      .item       (front_item),
      .item_stall (front_stall)
   );

   // Decoupling queue, so each part can stall on its own.
   hgd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_stall (front_stall),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_stall  (queue_stall),
      .pop_item   (queue_item)
   );

   // Mode machine and result register.
   hgd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (queue_valid),
      .in_stall  (queue_stall),
      .in_item   (queue_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
